// File: hw/rtl/arpc_pkg.sv
// Package for the ARP cache responder: sizes, field widths, protocol constants,
// register indexes and the cache write request type. No dependencies.
package arpc_pkg;

  localparam int ENTRIES = 8;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam int IP_W    = 32;
  localparam int MAC_W   = 48;
  localparam int HDR_W   = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 48;

  localparam logic [HDR_W-1:0] MIN_FRAME   = 16'd42;
  localparam logic [HDR_W-1:0] HW_ETHERNET = 16'h0001;
  localparam logic [HDR_W-1:0] PROTO_IPV4  = 16'h0800;
  localparam logic [HDR_W-1:0] OP_REQUEST  = 16'd1;

  localparam logic [IP_W-1:0] LOCAL_IP_RESET = 32'h0A00_020F;

  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_IP  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_MAC = 1'd1;

  localparam logic OPER_RECEIVE = 1'b0;
  localparam logic OPER_LOOKUP  = 1'b1;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
  } arpc_wr_t;

endpackage

// File: hw/rtl/arpc_ifs.sv
// Channel interfaces of the ARP cache responder: request in, result out, config write.
// Depends on arpc_pkg for the field widths.
interface arpc_in_if;
  import arpc_pkg::*;
  logic             valid;
  logic             ready;
  logic             operation;
  logic [HDR_W-1:0] frame_length;
  logic [HDR_W-1:0] hw_type;
  logic [HDR_W-1:0] ptype;
  logic [HDR_W-1:0] arp_opcode;
  logic [MAC_W-1:0] src_mac;
  logic [IP_W-1:0]  src_ip;
  logic [IP_W-1:0]  tgt_ip;
  logic [IP_W-1:0]  query_ip;

  modport source (output valid, operation, frame_length, hw_type, ptype, arp_opcode,
                  src_mac, src_ip, tgt_ip, query_ip, input ready);
  modport sink   (input valid, operation, frame_length, hw_type, ptype, arp_opcode,
                  src_mac, src_ip, tgt_ip, query_ip, output ready);
endinterface

interface arpc_out_if;
  import arpc_pkg::*;
  logic             valid;
  logic             ready;
  logic             lookup_hit;
  logic [MAC_W-1:0] lookup_mac;
  logic             packet_accepted;
  logic             send_reply;
  logic [MAC_W-1:0] reply_mac;
  logic [IP_W-1:0]  reply_ip;

  modport source (output valid, lookup_hit, lookup_mac, packet_accepted, send_reply,
                  reply_mac, reply_ip, input ready);
  modport sink   (input valid, lookup_hit, lookup_mac, packet_accepted, send_reply,
                  reply_mac, reply_ip, output ready);
endinterface

interface arpc_cfg_if;
  import arpc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/arpc_store.sv
// Cache storage: IP and MAC memories with one registered read port and one write port,
// plus the per-entry valid bits in flip-flops. Depends on arpc_pkg.
module arpc_store (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [arpc_pkg::IDX_W-1:0]     rd_addr,
  output logic [arpc_pkg::IP_W-1:0]      rd_ip,
  output logic [arpc_pkg::MAC_W-1:0]     rd_mac,
  output logic [arpc_pkg::ENTRIES-1:0]   vld,
  input  arpc_pkg::arpc_wr_t             wr
);
  import arpc_pkg::*;

  logic [IP_W-1:0]    ip_mem  [ENTRIES];
  logic [MAC_W-1:0]   mac_mem [ENTRIES];
  logic [IP_W-1:0]    rd_ip_r;
  logic [MAC_W-1:0]   rd_mac_r;
  logic [ENTRIES-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      ip_mem[wr.addr]  <= wr.ip;
      mac_mem[wr.addr] <= wr.mac;
    end
    rd_ip_r  <= ip_mem[rd_addr];
    rd_mac_r <= mac_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr.en) begin
      vld_r[wr.addr] <= 1'b1;
    end
  end

  assign rd_ip  = rd_ip_r;
  assign rd_mac = rd_mac_r;
  assign vld    = vld_r;

endmodule

// File: hw/rtl/arp_cache_responder_core.sv
// ARP cache responder: an eight-entry IPv4-to-MAC cache held in a synchronous memory
// with a registered read. One request is handled at a time. The cache is scanned one
// entry per cycle through the single memory read port, stopping early on a match, and a
// received packet is written back on the final scan cycle. A request passes through the
// scan and done states before its result is loaded into the output register; a rejected
// packet skips the scan and goes straight to the done state. The result sits in an
// output register, so a new request is taken while the previous result waits. Config
// writes are always taken; the local MAC is accepted but not stored, as no result field
// depends on it.
// Depends on arpc_pkg, the arpc_*_if interfaces and arpc_store.
module arp_cache_responder_core (
  input  logic       clk,
  input  logic       rst_n,
  arpc_in_if.sink    in_ch,
  arpc_out_if.source out_ch,
  arpc_cfg_if.sink   cfg_ch
);
  import arpc_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  logic [1:0]       state_r;
  logic [IP_W-1:0]  local_ip_r;

  // item held for the scan
  logic             op_r;
  logic [IP_W-1:0]  key_r;
  logic [MAC_W-1:0] smac_r;

  // scan control
  logic [IDX_W-1:0] iss_r;
  logic             iss_end_r;
  logic             chk_vld_r;
  logic [IDX_W-1:0] chk_idx_r;
  logic             free_found_r;
  logic [IDX_W-1:0] free_idx_r;

  // pending result
  logic             res_hit_r;
  logic [MAC_W-1:0] res_lmac_r;
  logic             res_acc_r;
  logic             res_rep_r;
  logic [MAC_W-1:0] res_rmac_r;
  logic [IP_W-1:0]  res_rip_r;

  // output register
  logic             out_valid_r;
  logic             out_hit_r;
  logic [MAC_W-1:0] out_lmac_r;
  logic             out_acc_r;
  logic             out_rep_r;
  logic [MAC_W-1:0] out_rmac_r;
  logic [IP_W-1:0]  out_rip_r;

  logic               in_fire;
  logic               pkt_ok;
  logic               want_reply;
  logic [IP_W-1:0]    in_key;
  logic [IP_W-1:0]    rd_ip;
  logic [MAC_W-1:0]   rd_mac;
  logic [ENTRIES-1:0] vld;
  logic               ent_vld;
  logic               match;
  logic               last;
  logic               finish;
  logic               free_now;
  logic [IDX_W-1:0]   slot;
  logic               issue;
  logic               load_out;
  arpc_wr_t           wr;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign pkt_ok = (in_ch.frame_length >= MIN_FRAME) && (in_ch.hw_type == HW_ETHERNET)
               && (in_ch.ptype == PROTO_IPV4);
  assign want_reply = (in_ch.operation == OPER_RECEIVE) && pkt_ok
                   && (in_ch.arp_opcode == OP_REQUEST) && (in_ch.tgt_ip == local_ip_r);
  assign in_key = (in_ch.operation == OPER_LOOKUP) ? in_ch.query_ip : in_ch.src_ip;

  // check stage sees the entry issued in the previous cycle
  assign ent_vld  = vld[chk_idx_r];
  assign match    = chk_vld_r && ent_vld && (rd_ip == key_r);
  assign last     = chk_vld_r && (chk_idx_r == LAST_IDX);
  assign finish   = (state_r == ST_SCAN) && (match || last);
  assign free_now = chk_vld_r && !ent_vld && !free_found_r;
  assign issue    = (state_r == ST_SCAN) && !iss_end_r;

  // matching entry first, then lowest free entry, else evict entry 0
  always_comb begin
    priority if (match)        slot = chk_idx_r;
    else if (free_found_r)     slot = free_idx_r;
    else if (free_now)         slot = chk_idx_r;
    else                       slot = '0;
  end

  assign wr.en   = finish && (op_r == OPER_RECEIVE);
  assign wr.addr = slot;
  assign wr.ip   = key_r;
  assign wr.mac  = smac_r;

  arpc_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (iss_r),
    .rd_ip   (rd_ip),
    .rd_mac  (rd_mac),
    .vld     (vld),
    .wr      (wr)
  );

  assign load_out = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      local_ip_r   <= LOCAL_IP_RESET;
      iss_r        <= '0;
      iss_end_r    <= 1'b0;
      chk_vld_r    <= 1'b0;
      free_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        unique case (cfg_ch.index)
          CFG_LOCAL_IP:  local_ip_r <= cfg_ch.data[IP_W-1:0];
          CFG_LOCAL_MAC: ;
          default:       ;
        endcase
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            iss_r        <= '0;
            iss_end_r    <= 1'b0;
            chk_vld_r    <= 1'b0;
            free_found_r <= 1'b0;
            // rejected packets skip the scan and leave the cache alone
            state_r <= ((in_ch.operation == OPER_LOOKUP) || pkt_ok) ? ST_SCAN : ST_DONE;
          end
        end
        ST_SCAN: begin
          if (issue) begin
            iss_r <= iss_r + 1'b1;
            if (iss_r == LAST_IDX) begin
              iss_end_r <= 1'b1;
            end
          end
          chk_vld_r <= issue;
          if (free_now) begin
            free_found_r <= 1'b1;
          end
          if (finish) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (load_out) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase

      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r       <= in_ch.operation;
      key_r      <= in_key;
      smac_r     <= in_ch.src_mac;
      res_hit_r  <= 1'b0;
      res_lmac_r <= '0;
      res_acc_r  <= (in_ch.operation == OPER_RECEIVE) && pkt_ok;
      res_rep_r  <= want_reply;
      res_rmac_r <= want_reply ? in_ch.src_mac : '0;
      res_rip_r  <= want_reply ? in_ch.src_ip : '0;
    end
    if (state_r == ST_SCAN) begin
      chk_idx_r <= iss_r;
      if (free_now) begin
        free_idx_r <= chk_idx_r;
      end
      if (match && (op_r == OPER_LOOKUP)) begin
        res_hit_r  <= 1'b1;
        res_lmac_r <= rd_mac;
      end
    end
    if (load_out) begin
      out_hit_r  <= res_hit_r;
      out_lmac_r <= res_lmac_r;
      out_acc_r  <= res_acc_r;
      out_rep_r  <= res_rep_r;
      out_rmac_r <= res_rmac_r;
      out_rip_r  <= res_rip_r;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.lookup_hit      = out_hit_r;
  assign out_ch.lookup_mac      = out_lmac_r;
  assign out_ch.packet_accepted = out_acc_r;
  assign out_ch.send_reply      = out_rep_r;
  assign out_ch.reply_mac       = out_rmac_r;
  assign out_ch.reply_ip        = out_rip_r;

endmodule

// File: sim/arpc_tb_pkg.sv
// Answer tracker for the ARP cache responder bench: mirrors the cache and local address,
// queues the answer owed for each accepted request and checks results in order.
// Depends on arpc_pkg for sizes, widths, protocol constants and register indexes.
package arpc_tb_pkg;
  import arpc_pkg::*;

  typedef struct packed {
    logic             operation;
    logic [HDR_W-1:0] frame_length;
    logic [HDR_W-1:0] hw_type;
    logic [HDR_W-1:0] ptype;
    logic [HDR_W-1:0] arp_opcode;
    logic [MAC_W-1:0] src_mac;
    logic [IP_W-1:0]  src_ip;
    logic [IP_W-1:0]  tgt_ip;
    logic [IP_W-1:0]  query_ip;
  } arp_request_t;

  typedef struct packed {
    logic             lookup_hit;
    logic [MAC_W-1:0] lookup_mac;
    logic             packet_accepted;
    logic             send_reply;
    logic [MAC_W-1:0] reply_mac;
    logic [IP_W-1:0]  reply_ip;
  } arp_answer_t;

  class arp_answer_tracker;
    logic [IP_W-1:0]  local_ip;
    logic [MAC_W-1:0] local_mac;
    logic [IP_W-1:0]  entry_ip    [ENTRIES];
    logic [MAC_W-1:0] entry_mac   [ENTRIES];
    bit               entry_valid [ENTRIES];
    arp_answer_t      owed_answers[$];
    int               error_count;

    function new();
      local_ip    = LOCAL_IP_RESET;
      local_mac   = '0;
      error_count = 0;
      foreach (entry_valid[i]) begin
        entry_valid[i] = 1'b0;
        entry_ip[i]    = '0;
        entry_mac[i]   = '0;
      end
    endfunction

    function void report(string msg);
      $display("MISMATCH: %s", msg);
      error_count++;
    endfunction

    function int pending();
      return owed_answers.size();
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_LOCAL_IP:  local_ip  = value[IP_W-1:0];
        CFG_LOCAL_MAC: local_mac = value[MAC_W-1:0];
        default: ;
      endcase
    endfunction

    // Matching valid entry wins, else lowest free slot, else evict entry 0.
    function void cache_sender(logic [IP_W-1:0] ip, logic [MAC_W-1:0] mac);
      int  slot;
      bit  matched;
      slot    = -1;
      matched = 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        if (!matched) begin
          if (!entry_valid[i]) begin
            if (slot < 0) slot = i;
          end else if (entry_ip[i] == ip) begin
            slot    = i;
            matched = 1'b1;
          end
        end
      end
      if (slot < 0) slot = 0;
      entry_ip[slot]    = ip;
      entry_mac[slot]   = mac;
      entry_valid[slot] = 1'b1;
    endfunction

    function arp_answer_t resolve(arp_request_t r);
      arp_answer_t a;
      a = '0;
      if (r.operation == OPER_LOOKUP) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (!a.lookup_hit && entry_valid[i] && entry_ip[i] == r.query_ip) begin
            a.lookup_hit = 1'b1;
            a.lookup_mac = entry_mac[i];
          end
        end
      end else if (r.frame_length >= MIN_FRAME && r.hw_type == HW_ETHERNET &&
                   r.ptype == PROTO_IPV4) begin
        cache_sender(r.src_ip, r.src_mac);
        a.packet_accepted = 1'b1;
        if (r.arp_opcode == OP_REQUEST && r.tgt_ip == local_ip) begin
          a.send_reply = 1'b1;
          a.reply_mac  = r.src_mac;
          a.reply_ip   = r.src_ip;
        end
      end
      return a;
    endfunction

    function void note_request(arp_request_t r);
      owed_answers.push_back(resolve(r));
    endfunction

    function void check_result(arp_answer_t got);
      arp_answer_t want;
      if (owed_answers.size() == 0) begin
        report($sformatf("result with nothing owed: %h", got));
        return;
      end
      want = owed_answers.pop_front();
      if (got.lookup_hit !== want.lookup_hit)
        report($sformatf("lookup_hit exp %b got %b", want.lookup_hit, got.lookup_hit));
      if (got.lookup_mac !== want.lookup_mac)
        report($sformatf("lookup_mac exp %h got %h", want.lookup_mac, got.lookup_mac));
      if (got.packet_accepted !== want.packet_accepted)
        report($sformatf("packet_accepted exp %b got %b", want.packet_accepted,
                         got.packet_accepted));
      if (got.send_reply !== want.send_reply)
        report($sformatf("send_reply exp %b got %b", want.send_reply, got.send_reply));
      if (got.reply_mac !== want.reply_mac)
        report($sformatf("reply_mac exp %h got %h", want.reply_mac, got.reply_mac));
      if (got.reply_ip !== want.reply_ip)
        report($sformatf("reply_ip exp %h got %h", want.reply_ip, got.reply_ip));
    endfunction
  endclass

endpackage

// File: sim/tb_arp_cache_responder_core.sv
// Bench for arp_cache_responder_core: directed and random requests with random stalls on
// both channels, checked in order against the answer tracker.
// Depends on arpc_pkg, the arpc_*_if interfaces and arpc_tb_pkg.
module tb_arp_cache_responder_core;
  timeunit 1ns;
  timeprecision 1ps;
  import arpc_pkg::*;
  import arpc_tb_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 400;
  localparam int POOL_SIZE   = 12;
  localparam int PHASE_ITEMS = 250;

  logic clk = 1'b0;
  logic rst_n;

  arpc_in_if  in_ch();
  arpc_out_if out_ch();
  arpc_cfg_if cfg_ch();

  arp_cache_responder_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  arp_answer_tracker book;
  logic [IP_W-1:0]   cur_local_ip;
  logic [IP_W-1:0]   host_pool [POOL_SIZE];
  arp_request_t      directed_reqs[$];
  int                cycle_count;
  int                results_seen;
  int                stall_left;
  int                mode_left;
  bit                hold_done;
  bit                eager;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [MAC_W-1:0] random_mac();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[MAC_W-1:0];
  endfunction

  function automatic arp_request_t make_packet(logic [HDR_W-1:0] len, logic [HDR_W-1:0] hw,
                                               logic [HDR_W-1:0] proto, logic [HDR_W-1:0] op,
                                               logic [MAC_W-1:0] mac, logic [IP_W-1:0] sip,
                                               logic [IP_W-1:0] tip);
    arp_request_t r;
    r = '0;
    r.operation    = OPER_RECEIVE;
    r.frame_length = len;
    r.hw_type      = hw;
    r.ptype        = proto;
    r.arp_opcode   = op;
    r.src_mac      = mac;
    r.src_ip       = sip;
    r.tgt_ip       = tip;
    return r;
  endfunction

  function automatic arp_request_t make_lookup(logic [IP_W-1:0] q);
    arp_request_t r;
    r = '0;
    r.operation = OPER_LOOKUP;
    r.query_ip  = q;
    return r;
  endfunction

  // Mostly well-formed packets and lookups on a small host pool, so the cache fills,
  // updates and evicts; the rest carries one or more broken header fields.
  function automatic arp_request_t random_request();
    arp_request_t r;
    int           pick;
    int           r2;
    r.operation    = OPER_RECEIVE;
    r.frame_length = 16'($urandom);
    r.hw_type      = 16'($urandom);
    r.ptype        = 16'($urandom);
    r.arp_opcode   = 16'($urandom);
    r.src_mac      = random_mac();
    r.src_ip       = $urandom;
    r.tgt_ip       = $urandom;
    r.query_ip     = $urandom;
    pick = $urandom_range(0, 99);
    if (pick >= 45 && pick < 80) begin
      r.operation = OPER_LOOKUP;
      if ($urandom_range(0, 99) < 85) r.query_ip = host_pool[$urandom_range(0, POOL_SIZE-1)];
      return r;
    end
    r2 = $urandom_range(0, 99);
    if (r2 < 80)      r.frame_length = 16'($urandom_range(42, 1518));
    else if (r2 < 90) r.frame_length = MIN_FRAME;
    else              r.frame_length = 16'hFFFF;
    r.hw_type = HW_ETHERNET;
    r.ptype   = PROTO_IPV4;
    r2 = $urandom_range(0, 99);
    if (r2 < 70)      r.arp_opcode = OP_REQUEST;
    else if (r2 < 90) r.arp_opcode = 16'd2;
    r.src_ip = host_pool[$urandom_range(0, POOL_SIZE-1)];
    r2 = $urandom_range(0, 99);
    if (r2 < 50)      r.tgt_ip = cur_local_ip;
    else if (r2 < 75) r.tgt_ip = host_pool[$urandom_range(0, POOL_SIZE-1)];
    if (pick >= 80) begin
      case ($urandom_range(0, 3))
        0: r.frame_length = 16'($urandom_range(0, 41));
        1: r.hw_type      = 16'($urandom);
        2: r.ptype        = 16'($urandom);
        default: begin
          r.frame_length = 16'($urandom);
          r.hw_type      = 16'($urandom);
          r.ptype        = 16'($urandom);
        end
      endcase
    end
    return r;
  endfunction

  task automatic send_request(input arp_request_t r, input bit with_gaps);
    int gap;
    @(negedge clk);
    in_ch.operation    = r.operation;
    in_ch.frame_length = r.frame_length;
    in_ch.hw_type      = r.hw_type;
    in_ch.ptype        = r.ptype;
    in_ch.arp_opcode   = r.arp_opcode;
    in_ch.src_mac      = r.src_mac;
    in_ch.src_ip       = r.src_ip;
    in_ch.tgt_ip       = r.tgt_ip;
    in_ch.query_ip     = r.query_ip;
    in_ch.valid        = 1'b1;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    book.note_request(r);
    gap = with_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Hold the request side until every owed answer has come back.
  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (book.pending() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_ch.index = idx;
    cfg_ch.data  = value;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    book.set_register(idx, value);
    if (idx == CFG_LOCAL_IP) cur_local_ip = value[IP_W-1:0];
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic build_directed();
    logic [IP_W-1:0] other;
    other = cur_local_ip ^ 32'h1;
    directed_reqs.push_back(make_lookup(32'h0));
    directed_reqs.push_back(make_lookup(32'hFFFF_FFFF));
    // header checks: short frame, wrong hardware type, wrong protocol
    directed_reqs.push_back(make_packet(16'd41, HW_ETHERNET, PROTO_IPV4, OP_REQUEST,
                                        48'h1, 32'h0A00_0001, cur_local_ip));
    directed_reqs.push_back(make_packet(16'd0, HW_ETHERNET, PROTO_IPV4, OP_REQUEST,
                                        48'h1, 32'h0A00_0001, cur_local_ip));
    directed_reqs.push_back(make_packet(MIN_FRAME, 16'h0, PROTO_IPV4, OP_REQUEST,
                                        48'h1, 32'h0A00_0001, cur_local_ip));
    directed_reqs.push_back(make_packet(MIN_FRAME, 16'hFFFF, PROTO_IPV4, OP_REQUEST,
                                        48'h1, 32'h0A00_0001, cur_local_ip));
    directed_reqs.push_back(make_packet(MIN_FRAME, HW_ETHERNET, 16'h0806, OP_REQUEST,
                                        48'h1, 32'h0A00_0001, cur_local_ip));
    directed_reqs.push_back(make_packet(MIN_FRAME, HW_ETHERNET, 16'hFFFF, OP_REQUEST,
                                        48'h1, 32'h0A00_0001, cur_local_ip));
    // accepted packets filling the cache
    directed_reqs.push_back(make_packet(MIN_FRAME, HW_ETHERNET, PROTO_IPV4, OP_REQUEST,
                                        48'hFFFF_FFFF_FFFF, 32'h0A00_0001, cur_local_ip));
    directed_reqs.push_back(make_packet(16'hFFFF, HW_ETHERNET, PROTO_IPV4, 16'd2,
                                        48'h0, 32'h0A00_0002, cur_local_ip));
    directed_reqs.push_back(make_packet(16'd60, HW_ETHERNET, PROTO_IPV4, OP_REQUEST,
                                        48'h0000_1111_2222, 32'h0A00_0003, other));
    directed_reqs.push_back(make_packet(16'd60, HW_ETHERNET, PROTO_IPV4, 16'd0,
                                        48'h0000_3333_4444, 32'h0A00_0004, cur_local_ip));
    directed_reqs.push_back(make_packet(16'd60, HW_ETHERNET, PROTO_IPV4, 16'hFFFF,
                                        48'h0000_5555_6666, 32'h0A00_0005, cur_local_ip));
    // update an existing entry in place
    directed_reqs.push_back(make_packet(16'd60, HW_ETHERNET, PROTO_IPV4, OP_REQUEST,
                                        48'hAAAA_BBBB_CCCC, 32'h0A00_0001, cur_local_ip));
    directed_reqs.push_back(make_lookup(32'h0A00_0001));
    directed_reqs.push_back(make_packet(16'd60, HW_ETHERNET, PROTO_IPV4, 16'd2,
                                        48'h0000_0000_0006, 32'h0A00_0006, other));
    directed_reqs.push_back(make_packet(16'd60, HW_ETHERNET, PROTO_IPV4, 16'd2,
                                        48'h0000_0000_0007, 32'h0000_0000, other));
    directed_reqs.push_back(make_packet(16'd60, HW_ETHERNET, PROTO_IPV4, 16'd2,
                                        48'h0000_0000_0008, 32'hFFFF_FFFF, other));
    // cache full: the next new sender evicts entry 0
    directed_reqs.push_back(make_packet(16'd60, HW_ETHERNET, PROTO_IPV4, OP_REQUEST,
                                        48'h0000_0000_0009, 32'h0A00_0009, cur_local_ip));
    directed_reqs.push_back(make_lookup(32'h0A00_0001));
    directed_reqs.push_back(make_lookup(32'h0A00_0009));
    directed_reqs.push_back(make_lookup(32'h0A00_0002));
    directed_reqs.push_back(make_lookup(32'h0000_0000));
    directed_reqs.push_back(make_lookup(32'hFFFF_FFFF));
  endtask

  // Result side: random stalls, calm stretches and one long hold-off.
  initial begin
    results_seen = 0;
    stall_left   = 0;
    mode_left    = 0;
    hold_done    = 1'b0;
    eager        = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        mode_left = $urandom_range(50, 300);
        eager     = ($urandom_range(0, 2) == 0);
      end
      mode_left--;
      if (stall_left > 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else if (!hold_done && results_seen >= 300) begin
        hold_done    = 1'b1;
        stall_left   = HOLD_CYCLES - 1;
        out_ch.ready = 1'b0;
      end else if (!eager && $urandom_range(0, 99) < 25) begin
        stall_left   = pick_gap();
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = 1'b1;
      end
      @(posedge clk);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        book.check_result('{lookup_hit:      out_ch.lookup_hit,
                            lookup_mac:      out_ch.lookup_mac,
                            packet_accepted: out_ch.packet_accepted,
                            send_reply:      out_ch.send_reply,
                            reply_mac:       out_ch.reply_mac,
                            reply_ip:        out_ch.reply_ip});
        results_seen++;
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    logic [IP_W-1:0]  phase_ip;
    logic [MAC_W-1:0] phase_mac;
    book         = new();
    cur_local_ip = LOCAL_IP_RESET;
    rst_n        = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.operation    = OPER_RECEIVE;
    in_ch.frame_length = '0;
    in_ch.hw_type      = '0;
    in_ch.ptype        = '0;
    in_ch.arp_opcode   = '0;
    in_ch.src_mac      = '0;
    in_ch.src_ip       = '0;
    in_ch.tgt_ip       = '0;
    in_ch.query_ip     = '0;
    out_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = CFG_LOCAL_IP;
    cfg_ch.data        = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed part runs on the reset local address
    build_directed();
    foreach (directed_reqs[i]) send_request(directed_reqs[i], 1'b1);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin phase_ip = 32'h0;          phase_mac = 48'h0;               end
        1: begin phase_ip = 32'hFFFF_FFFF;  phase_mac = 48'hFFFF_FFFF_FFFF;  end
        2: begin phase_ip = $urandom;       phase_mac = random_mac();        end
        default: begin phase_ip = LOCAL_IP_RESET; phase_mac = random_mac(); end
      endcase
      write_register(CFG_LOCAL_IP, {16'h0, phase_ip});
      write_register(CFG_LOCAL_MAC, phase_mac);
      host_pool[0] = 32'h0;
      host_pool[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < POOL_SIZE; i++) host_pool[i] = $urandom;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 0 && n == 120) drain();
        send_request(random_request(), (n % 200) >= 40);
      end
      drain();
    end

    repeat (ENTRIES + 3 + 8) @(posedge clk);
    if (book.pending() != 0) book.report("answers still owed at end of run");
    if (book.error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
